>>> src/assert_macros.svh
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is asserted.
`define PT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("point transform check failed");

// Concurrent check on the rising clock, live during reset too.
`define PT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("point transform check failed");

`endif

>>> src/pt4_pkg.sv
package pt4_pkg;

  localparam int COORD_W  = 32;
  localparam int COEF_W   = 64;
  localparam int NUM_REGS = 8;
  localparam int PROD_W   = 65;   // 32-bit element times 33-bit operand
  localparam int SUM_W    = 67;   // three products plus offset, no overflow
  localparam int QUO_W    = 33;   // quotient bits kept by the divider
  localparam int DIV_DEPTH  = QUO_W + 1;
  localparam int PIPE_DEPTH = DIV_DEPTH + 5;

  localparam logic [2:0] OP_POINT     = 3'd0;
  localparam logic [2:0] OP_VECTOR    = 3'd1;
  localparam logic [2:0] OP_PERSP     = 3'd2;
  localparam logic [2:0] OP_INV_POINT = 3'd3;
  localparam logic [2:0] OP_INV_VEC   = 3'd4;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      ok;
    logic                      saturated;
  } out_t;

endpackage

>>> src/pt4_dot_lane.sv
module pt4_dot_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic signed [pt4_pkg::COORD_W-1:0]     c_i [3],
  input  logic signed [pt4_pkg::COORD_W:0]       v_i [3],
  input  logic signed [pt4_pkg::COORD_W-1:0]     t_i,
  output logic signed [pt4_pkg::SUM_W-FRAC_BITS-1:0] res_o
);

  localparam int DW = pt4_pkg::SUM_W - FRAC_BITS;

  logic signed [pt4_pkg::PROD_W-1:0] p_q [3];
  logic signed [pt4_pkg::SUM_W-1:0]  off_q;
  logic signed [pt4_pkg::SUM_W-1:0]  sum;

  // stage a: products, translation scaled up with the rounding half added
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      p_q[j] <= pt4_pkg::PROD_W'(c_i[j]) * pt4_pkg::PROD_W'(v_i[j]);
    end
    off_q <= (pt4_pkg::SUM_W'(t_i) <<< FRAC_BITS)
           + (pt4_pkg::SUM_W'(1) <<< (FRAC_BITS - 1));
  end

  assign sum = pt4_pkg::SUM_W'(p_q[0]) + pt4_pkg::SUM_W'(p_q[1])
             + pt4_pkg::SUM_W'(p_q[2]) + off_q;

  // stage b: floor shift gives round half up
  always_ff @(posedge clk_i) begin
    res_o <= DW'(sum >>> FRAC_BITS);
  end

endmodule

>>> src/pt4_div_lane.sv
module pt4_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic [pt4_pkg::SUM_W:0]                    num_i,
  input  logic [pt4_pkg::SUM_W-FRAC_BITS-1:0]        den_i,
  output logic [pt4_pkg::QUO_W-1:0]                  quo_o,
  output logic                                       ovf_o
);

  localparam int DW = pt4_pkg::SUM_W - FRAC_BITS;
  localparam int NW = pt4_pkg::SUM_W + 1;
  localparam int QB = pt4_pkg::QUO_W;

  logic [DW:0]   rem_q [QB+1];
  logic [NW-1:0] num_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic          ovf_q [QB+1];
  logic [DW:0]   cand  [QB+1];
  logic          ge    [QB+1];
  logic [NW-1:0] top_bits;

  assign top_bits = num_i >> QB;

  always_comb begin
    cand[0] = '0;
    ge[0]   = 1'b0;
    for (int j = 1; j <= QB; j++) begin
      cand[j] = {rem_q[j-1][DW-1:0], num_q[j-1][QB-j]};
      ge[j]   = cand[j] >= {1'b0, den_q[j-1]};
    end
  end

  // one quotient bit per stage, restoring
  always_ff @(posedge clk_i) begin
    rem_q[0] <= (DW+1)'(top_bits);
    num_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= top_bits >= NW'(den_i);
    for (int j = 1; j <= QB; j++) begin
      rem_q[j] <= ge[j] ? cand[j] - {1'b0, den_q[j-1]} : cand[j];
      num_q[j] <= num_q[j-1];
      den_q[j] <= den_q[j-1];
      quo_q[j] <= quo_q[j-1] | (QB'(ge[j]) << (QB - j));
      ovf_q[j] <= ovf_q[j-1];
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

>>> src/point_transform_4x4.sv
// Homogeneous 4x4 vertex transform with perspective divide. One transaction is accepted
// every clock cycle (busy_o stays low) and its result appears on res_o with res_valid_o
// high for exactly one cycle; results come out in accept order. The divider is a
// 34-stage restoring pipeline (an overflow check, then one quotient bit per stage for
// 33 bits), used by every transaction so all modes share one pipeline depth.
// The receiver cannot stall, so results must be taken when shown. The matrix registers
// reset to identity and may only be written while no transaction is in flight.
module point_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  pt4_pkg::in_t                    in_i,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [pt4_pkg::COEF_W-1:0]      cfg_data_i,
  output logic                            res_valid_o,
  output pt4_pkg::out_t                   res_o
);

  localparam int CW = pt4_pkg::COORD_W;
  localparam int DW = pt4_pkg::SUM_W - FRAC_BITS;
  localparam int NW = pt4_pkg::SUM_W + 1;
  localparam int QB = pt4_pkg::QUO_W;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  typedef struct packed {
    logic                   persp;
    logic                   affine;
    logic                   wzero;
    logic [2:0]             neg;
    logic [2:0][CW-1:0]     aff;
    logic                   aff_sat;
  } side_t;

  // ---------------- matrix registers ----------------
  logic [pt4_pkg::COEF_W-1:0] coef_q [pt4_pkg::NUM_REGS];
  logic signed [CW-1:0]       el [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pt4_pkg::NUM_REGS; i++) begin
        if (i == 0 || i == 5) begin
          coef_q[i] <= {{CW{1'b0}}, ONE};
        end else if (i == 2 || i == 7) begin
          coef_q[i] <= {ONE, {CW{1'b0}}};
        end else begin
          coef_q[i] <= '0;
        end
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) el[i] = coef_q[i/2][(i%2)*CW +: CW];
  end

  // never stalls
  assign busy_o = 1'b0;

  // ---------------- valid pipeline ----------------
  logic vld_q [pt4_pkg::PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pt4_pkg::PIPE_DEPTH; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int i = 1; i < pt4_pkg::PIPE_DEPTH; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // ---------------- operand select (stage 0) ----------------
  logic signed [CW-1:0] c_d [4][3];
  logic signed [CW-1:0] c_q [4][3];
  logic signed [CW:0]   v_d [3];
  logic signed [CW:0]   v_q [3];
  logic signed [CW-1:0] t_d [4];
  logic signed [CW-1:0] t_q [4];
  logic signed [CW-1:0] in_v [3];
  logic [2:0]           op_q [3];
  logic                 inv;
  logic                 use_t;

  always_comb begin
    in_v[0] = in_i.in_x;
    in_v[1] = in_i.in_y;
    in_v[2] = in_i.in_z;
    inv   = (in_i.opcode == pt4_pkg::OP_INV_POINT) || (in_i.opcode == pt4_pkg::OP_INV_VEC);
    use_t = (in_i.opcode == pt4_pkg::OP_POINT) || (in_i.opcode == pt4_pkg::OP_PERSP);
    for (int j = 0; j < 3; j++) begin
      if (in_i.opcode == pt4_pkg::OP_INV_POINT) begin
        v_d[j] = (CW+1)'(in_v[j]) - (CW+1)'(el[12+j]);
      end else begin
        v_d[j] = (CW+1)'(in_v[j]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      // inverse modes use the transposed rotation; lane w is only read in perspective mode
      for (int j = 0; j < 3; j++) begin
        c_d[k][j] = (inv && k < 3) ? el[4*k+j] : el[4*j+k];
      end
      t_d[k] = (use_t && !inv) ? el[12+k] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    v_q <= v_d;
    t_q <= t_d;
    op_q[0] <= in_i.opcode;
    op_q[1] <= op_q[0];
    op_q[2] <= op_q[1];
  end

  // ---------------- four dot-product lanes: x, y, z, w ----------------
  logic signed [DW-1:0] dot [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    pt4_dot_lane #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clk_i (clk_i),
      .c_i   (c_q[k]),
      .v_i   (v_q),
      .t_i   (t_q[k]),
      .res_o (dot[k])
    );
  end

  // ---------------- prep: saturate affine, set up divides ----------------
  localparam int  DIV_LEN = pt4_pkg::DIV_DEPTH + 1;
  logic [NW-1:0]  num_d [3];
  logic [NW-1:0]  num_q [3];
  logic [DW-1:0]  den_d;
  logic [DW-1:0]  den_q;
  logic [DW-1:0]  mag_a [3];
  side_t          side_d;
  side_t          side_q [DIV_LEN];

  always_comb begin
    den_d = dot[3][DW-1] ? DW'(-dot[3]) : DW'(dot[3]);
    side_d = '0;
    side_d.persp  = op_q[2] == pt4_pkg::OP_PERSP;
    side_d.affine = (op_q[2] == pt4_pkg::OP_POINT) || (op_q[2] == pt4_pkg::OP_VECTOR)
                 || (op_q[2] == pt4_pkg::OP_INV_POINT) || (op_q[2] == pt4_pkg::OP_INV_VEC);
    side_d.wzero  = dot[3] == '0;
    for (int k = 0; k < 3; k++) begin
      mag_a[k] = dot[k][DW-1] ? DW'(-dot[k]) : DW'(dot[k]);
      num_d[k] = (NW'(mag_a[k]) << FRAC_BITS) + NW'(den_d >> 1);
      side_d.neg[k] = dot[k][DW-1] ^ dot[3][DW-1];
      if (dot[k] > DW'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
        side_d.aff[k] = {1'b0, {(CW-1){1'b1}}};
        side_d.aff_sat = 1'b1;
      end else if (dot[k] < DW'(signed'({1'b1, {(CW-1){1'b0}}}))) begin
        side_d.aff[k] = {1'b1, {(CW-1){1'b0}}};
        side_d.aff_sat = 1'b1;
      end else begin
        side_d.aff[k] = CW'(dot[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    side_q[0] <= side_d;
    for (int i = 1; i < DIV_LEN; i++) side_q[i] <= side_q[i-1];
  end

  // ---------------- three divide lanes ----------------
  logic [QB-1:0] quo [3];
  logic          ovf [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    pt4_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .num_i (num_q[k]),
      .den_i (den_q),
      .quo_o (quo[k]),
      .ovf_o (ovf[k])
    );
  end

  // ---------------- merge ----------------
  side_t         sd;
  logic [CW-1:0] dv [3];
  logic          dsat;
  pt4_pkg::out_t res_d;
  pt4_pkg::out_t res_q;

  assign sd = side_q[DIV_LEN-1];

  always_comb begin
    dsat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (sd.neg[k]) begin
        if (ovf[k] || quo[k] > (QB'(1) << (CW-1))) begin
          dv[k] = {1'b1, {(CW-1){1'b0}}};
          dsat  = 1'b1;
        end else begin
          dv[k] = CW'(-quo[k]);
        end
      end else if (ovf[k] || quo[k][QB-1:CW-1] != '0) begin
        dv[k] = {1'b0, {(CW-1){1'b1}}};
        dsat  = 1'b1;
      end else begin
        dv[k] = CW'(quo[k]);
      end
    end
    res_d = '0;
    res_d.ok = 1'b1;
    if (sd.persp) begin
      if (sd.wzero) begin
        res_d.ok = 1'b0;
      end else begin
        res_d.out_x = dv[0];
        res_d.out_y = dv[1];
        res_d.out_z = dv[2];
        res_d.saturated = dsat;
      end
    end else if (sd.affine) begin
      res_d.out_x = sd.aff[0];
      res_d.out_y = sd.aff[1];
      res_d.out_z = sd.aff[2];
      res_d.saturated = sd.aff_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = vld_q[pt4_pkg::PIPE_DEPTH-1];

endmodule

>>> src/pt4_checker.sv
`include "assert_macros.svh"

module pt4_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        cfg_we_i,
  input logic                        res_valid_o,
  input pt4_pkg::out_t               res_o
);

  localparam int CW = pt4_pkg::COORD_W;

  logic at_limit;

  assign at_limit =
      (res_o.out_x == {1'b0, {(CW-1){1'b1}}}) || (res_o.out_x == {1'b1, {(CW-1){1'b0}}})
   || (res_o.out_y == {1'b0, {(CW-1){1'b1}}}) || (res_o.out_y == {1'b1, {(CW-1){1'b0}}})
   || (res_o.out_z == {1'b0, {(CW-1){1'b1}}}) || (res_o.out_z == {1'b1, {(CW-1){1'b0}}});

  // every result traces back to an accepted transaction a fixed latency earlier
  `PT_ASSERT(a_latency, clk_i, rst_ni,
    res_valid_o |-> $past(start_i && !busy_o, pt4_pkg::PIPE_DEPTH))

  // a zero w in perspective mode (ok low) gives zero coordinates and no saturation
  `PT_ASSERT(a_wzero, clk_i, rst_ni,
    (res_valid_o && !res_o.ok) |-> (res_o.out_x == '0 && res_o.out_y == '0
      && res_o.out_z == '0 && !res_o.saturated))

  // a clamped result shows at least one coordinate at a range limit
  `PT_ASSERT(a_sat_limit, clk_i, rst_ni,
    (res_valid_o && res_o.saturated) |-> at_limit)

  // config written only with pipe empty is up to the user; no result shows then
  `PT_ASSERT(a_cfg_idle, clk_i, rst_ni,
    cfg_we_i |-> !res_valid_o)

  // no result while reset is held
  `PT_ASSERT_ALWAYS(a_rst_quiet, clk_i,
    !rst_ni |-> !res_valid_o)

endmodule

bind point_transform_4x4 pt4_checker u_pt4_checker (.*);
